FILE: hw/rtl/vrf_pkg.sv
// shared types, register map codes and flag helpers for the via register file
// no dependencies; used by vrf_exec and via_register_file_with_irq_logic_core
`timescale 1ns / 1ps
`default_nettype none

package vrf_pkg;

   // bus access kinds
   typedef enum logic [1:0] {
      MODE_READ  = 2'd0,
      MODE_WRITE = 2'd1,
      MODE_RAISE = 2'd2,
      MODE_NONE  = 2'd3
   } mode_type;

   // standard 6522 register map
   typedef enum logic [3:0] {
      REG_ORB   = 4'd0,
      REG_ORA   = 4'd1,
      REG_DDRB  = 4'd2,
      REG_DDRA  = 4'd3,
      REG_T1CL  = 4'd4,
      REG_T1CH  = 4'd5,
      REG_T1LL  = 4'd6,
      REG_T1LH  = 4'd7,
      REG_T2CL  = 4'd8,
      REG_T2CH  = 4'd9,
      REG_SR    = 4'd10,
      REG_ACR   = 4'd11,
      REG_PCR   = 4'd12,
      REG_IFR   = 4'd13,
      REG_IER   = 4'd14,
      REG_ORANH = 4'd15
   } reg_addr_type;

   localparam logic [7:0]  ORB_RESET   = 8'hf0;
   localparam logic [15:0] COUNT_RESET = 16'hffff;
   localparam logic [7:0]  FLAG_MASK   = 8'h7f;
   localparam logic [7:0]  IRQ_SUMMARY = 8'h80;
   localparam logic [7:0]  FLAG_T1     = 8'h40;
   localparam logic [7:0]  FLAG_T2     = 8'h20;
   localparam logic [7:0]  FLAG_CB1    = 8'h10;
   localparam logic [7:0]  FLAG_CB2    = 8'h08;
   localparam logic [7:0]  PCR_CB2_SEL = 8'he0;
   localparam logic [7:0]  PCR_CB2_IND_A = 8'h20;
   localparam logic [7:0]  PCR_CB2_IND_B = 8'h60;
   localparam logic [7:0]  PB7_CLEAR   = 8'h7f;

   typedef struct packed {
      mode_type     mode;
      reg_addr_type reg_addr;
      logic [7:0]   write_data;
      logic [6:0]   raise_flags;
   } item_type;

   typedef struct packed {
      logic [7:0] device_data;
      logic       device_strobe;
      logic       latch_bit;
      logic [2:0] latch_index;
      logic       latch_valid;
      logic       irq_pulse;
      logic       access_error;
      logic [7:0] read_data;
   } result_type;

   // architectural state of the adapter
   typedef struct packed {
      logic [7:0]  orb;
      logic [7:0]  ddrb;
      logic [7:0]  ddra;
      logic [7:0]  t1cl;
      logic [7:0]  t1ch;
      logic [7:0]  t1ll;
      logic [7:0]  t1lh;
      logic [7:0]  t2cl;
      logic [7:0]  t2ch;
      logic [7:0]  acr;
      logic [7:0]  pcr;
      logic [7:0]  ifr;
      logic [7:0]  ier;
      logic [7:0]  oranh;
      logic [7:0]  t2_low_latch;
      logic [15:0] t1_count;
   } state_type;

   // state after reset: port b high nibble set, timer 1 count all ones
   localparam state_type STATE_RESET = '{orb: ORB_RESET, t1_count: COUNT_RESET, default: '0};

   // clear flags and recompute the summary bit
   function automatic logic [7:0] clear_flags(input logic [7:0] ifr, input logic [7:0] ier,
                                              input logic [7:0] mask);
      logic [7:0] f;
      f = ifr & ~mask & FLAG_MASK;
      if ((f & ier & FLAG_MASK) != 8'h00) begin
         f = f | IRQ_SUMMARY;
      end
      return f;
   endfunction

   // cb2 flag survives a port b access when pcr selects an independent cb2 mode
   function automatic logic [7:0] pb_clear_mask(input logic [7:0] pcr);
      logic [7:0] sel;
      sel = pcr & PCR_CB2_SEL;
      if (sel == PCR_CB2_IND_A || sel == PCR_CB2_IND_B) begin
         return FLAG_CB1;
      end
      return FLAG_CB1 | FLAG_CB2;
   endfunction

   // latch selections 0, 2 and 3 with data bit low address a device
   function automatic logic strobe_sel(input logic [7:0] pb);
      return (pb[3] == 1'b0) &&
             (pb[2:0] == 3'd0 || pb[2:0] == 3'd2 || pb[2:0] == 3'd3);
   endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/via_register_file_with_irq_logic_core.sv
// top level of the via register file: input register, state, result register
// depends on vrf_pkg and vrf_exec
`timescale 1ns / 1ps
`default_nettype none

// Register side of a 6522-style interface adapter. Each transfer on the req
// channel is one bus access (read, write or flag raise) and gives exactly one
// transfer on the rsp channel. An access is taken into an input register, its
// register file update and result are computed by combinational decode logic,
// and the result lands in an output register, which drives rsp_tvalid and
// rsp_tdata. With rsp_tready high an access is taken every clock;
// while a result waits on rsp, one more access is held in the input register
// and req_tready then stays low until the waiting result is taken.
// Reads and writes of ORA/IRA or SR raise access_error and change nothing.
module via_register_file_with_irq_logic_core (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   // reg_addr[3:0], write_data[11:4], raise_flags[18:12], zero [23:19]
   input  wire  [23:0] req_tdata,
   // mode[1:0]
   input  wire  [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   // read_data[7:0], access_error[8], irq_pulse[9], latch_valid[10],
   // latch_index[13:11], latch_bit[14], device_strobe[15], device_data[23:16]
   output logic [23:0] rsp_tdata
);

   logic                in_valid_ff, in_valid_in;
   vrf_pkg::item_type   in_item_ff, in_item_in;
   logic                out_valid_ff, out_valid_in;
   vrf_pkg::result_type out_res_ff, out_res_in;
   vrf_pkg::state_type  state_ff, state_in;
   vrf_pkg::state_type  state_nxt;
   vrf_pkg::result_type exec_res;
   logic                advance;
   logic                req_take;

   // handshake and stage movement
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   vrf_exec u_exec (
      .item      (in_item_ff),
      .state_cur (state_ff),
      .state_nxt (state_nxt),
      .result    (exec_res)
   );

   // next values
   always_comb begin
      in_valid_in  = req_take ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
      in_item_in   = in_item_ff;
      if (req_take) begin
         in_item_in.mode        = vrf_pkg::mode_type'(req_tuser);
         in_item_in.reg_addr    = vrf_pkg::reg_addr_type'(req_tdata[3:0]);
         in_item_in.write_data  = req_tdata[11:4];
         in_item_in.raise_flags = req_tdata[18:12];
      end
      out_valid_in = advance ? 1'b1 : (rsp_tready ? 1'b0 : out_valid_ff);
      out_res_in   = advance ? exec_res : out_res_ff;
      state_in     = advance ? state_nxt : state_ff;
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= vrf_pkg::STATE_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      in_item_ff <= in_item_in;
      out_res_ff <= out_res_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_res_ff;

   // summary bit always matches pending enabled flags
   a_ifr_summary : assert property (@(posedge clock) disable iff (reset)
      state_ff.ifr[7] == ((state_ff.ifr[6:0] & state_ff.ier[6:0]) != 7'd0))
      else $error("ifr summary bit out of step with flags");

   // enable register never holds bit 7
   a_ier_bit7 : assert property (@(posedge clock) disable iff (reset)
      !state_ff.ier[7])
      else $error("ier bit 7 stored");

   // an error result carries nothing else
   a_error_clean : assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_res_ff.access_error |->
         out_res_ff.read_data == 8'h00 && !out_res_ff.irq_pulse &&
         !out_res_ff.latch_valid && !out_res_ff.device_strobe)
      else $error("error result carries data");

   // latch fields are zero unless the latch was written
   a_latch_zero : assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_res_ff.latch_valid |->
         out_res_ff.latch_index == 3'd0 && !out_res_ff.latch_bit)
      else $error("latch fields set without latch write");

   // state changes only when an access advances
   a_state_hold : assert property (@(posedge clock) disable iff (reset)
      !$past(advance) && !$past(reset) |-> $stable(state_ff))
      else $error("state changed without an access");

endmodule

`default_nettype wire

FILE: hw/rtl/vrf_exec.sv
// single pass access logic: next state and result for one bus access
// depends on vrf_pkg
`timescale 1ns / 1ps
`default_nettype none

module vrf_exec (
   input  var vrf_pkg::item_type   item,
   input  var vrf_pkg::state_type  state_cur,
   output vrf_pkg::state_type      state_nxt,
   output vrf_pkg::result_type     result
);

   logic [7:0] pb_new;
   logic [7:0] pa_new;
   logic [7:0] ier_new;
   logic [7:0] ifr_sum;
   logic [7:0] pb_mask;
   logic [7:0] raised;

   // candidate values computed ahead of the access decode
   always_comb begin
      pb_mask = vrf_pkg::pb_clear_mask(state_cur.pcr);
      raised  = {1'b0, item.raise_flags};
      pa_new  = (state_cur.oranh & ~state_cur.ddra) | (item.write_data & state_cur.ddra);
      if (item.reg_addr == vrf_pkg::REG_T1CH) begin
         pb_new = (state_cur.orb & ~state_cur.ddrb) |
                  (state_cur.orb & vrf_pkg::PB7_CLEAR & state_cur.ddrb);
      end else begin
         pb_new = (state_cur.orb & ~state_cur.ddrb) | (item.write_data & state_cur.ddrb);
      end
      if (item.write_data[7]) begin
         ier_new = (state_cur.ier | item.write_data) & vrf_pkg::FLAG_MASK;
      end else begin
         ier_new = state_cur.ier & ~item.write_data & vrf_pkg::FLAG_MASK;
      end
      ifr_sum = state_cur.ifr & vrf_pkg::FLAG_MASK;
      if ((ifr_sum & ier_new) != 8'h00) begin
         ifr_sum = ifr_sum | vrf_pkg::IRQ_SUMMARY;
      end
   end

   // access decode
   always_comb begin
      state_nxt = state_cur;
      result    = '0;
      case (item.mode)
         vrf_pkg::MODE_RAISE: begin
            state_nxt.ifr = state_cur.ifr | raised;
            if ((state_cur.ier & raised) != 8'h00) begin
               state_nxt.ifr    = state_cur.ifr | raised | vrf_pkg::IRQ_SUMMARY;
               result.irq_pulse = 1'b1;
            end
         end
         vrf_pkg::MODE_READ: begin
            case (item.reg_addr)
               vrf_pkg::REG_ORA, vrf_pkg::REG_SR: begin
                  result.access_error = 1'b1;
               end
               vrf_pkg::REG_ORB: begin
                  state_nxt.ifr = vrf_pkg::clear_flags(state_cur.ifr, state_cur.ier, pb_mask);
                  result.read_data = state_cur.orb;
               end
               vrf_pkg::REG_T1CL: begin
                  state_nxt.ifr = vrf_pkg::clear_flags(state_cur.ifr, state_cur.ier,
                                                       vrf_pkg::FLAG_T1);
                  result.read_data = state_cur.t1_count[7:0];
               end
               vrf_pkg::REG_T1CH: result.read_data = state_cur.t1_count[15:8];
               vrf_pkg::REG_DDRB: result.read_data = state_cur.ddrb;
               vrf_pkg::REG_DDRA: result.read_data = state_cur.ddra;
               vrf_pkg::REG_T1LL: result.read_data = state_cur.t1ll;
               vrf_pkg::REG_T1LH: result.read_data = state_cur.t1lh;
               vrf_pkg::REG_T2CL: result.read_data = state_cur.t2cl;
               vrf_pkg::REG_T2CH: result.read_data = state_cur.t2ch;
               vrf_pkg::REG_ACR:  result.read_data = state_cur.acr;
               vrf_pkg::REG_PCR:  result.read_data = state_cur.pcr;
               vrf_pkg::REG_IFR:  result.read_data = state_cur.ifr;
               vrf_pkg::REG_IER:  result.read_data = state_cur.ier | vrf_pkg::IRQ_SUMMARY;
               vrf_pkg::REG_ORANH: result.read_data = state_cur.oranh;
               default: result = '0;
            endcase
         end
         vrf_pkg::MODE_WRITE: begin
            case (item.reg_addr)
               vrf_pkg::REG_ORA, vrf_pkg::REG_SR: begin
                  result.access_error = 1'b1;
               end
               // port b write drives the addressable latch
               vrf_pkg::REG_ORB, vrf_pkg::REG_T1CH: begin
                  state_nxt.orb = pb_new;
                  result.latch_valid = 1'b1;
                  result.latch_index = pb_new[2:0];
                  result.latch_bit   = pb_new[3];
                  if (vrf_pkg::strobe_sel(pb_new)) begin
                     result.device_strobe = 1'b1;
                     result.device_data   = state_cur.oranh;
                  end
                  if (item.reg_addr == vrf_pkg::REG_T1CH) begin
                     state_nxt.t1ch     = item.write_data;
                     state_nxt.t1lh     = item.write_data;
                     state_nxt.t1cl     = state_cur.t1ll;
                     state_nxt.t1_count = {item.write_data, state_cur.t1ll};
                     state_nxt.ifr = vrf_pkg::clear_flags(state_cur.ifr, state_cur.ier,
                                                          pb_mask | vrf_pkg::FLAG_T1);
                  end else begin
                     state_nxt.ifr = vrf_pkg::clear_flags(state_cur.ifr, state_cur.ier,
                                                          pb_mask);
                  end
               end
               vrf_pkg::REG_DDRB: state_nxt.ddrb = item.write_data;
               vrf_pkg::REG_DDRA: state_nxt.ddra = item.write_data;
               vrf_pkg::REG_PCR:  state_nxt.pcr  = item.write_data;
               vrf_pkg::REG_T1LH: state_nxt.t1lh = item.write_data;
               vrf_pkg::REG_T1CL, vrf_pkg::REG_T1LL: state_nxt.t1ll = item.write_data;
               vrf_pkg::REG_T2CL: state_nxt.t2_low_latch = item.write_data;
               vrf_pkg::REG_T2CH: begin
                  state_nxt.t2ch = item.write_data;
                  state_nxt.t2cl = state_cur.t2_low_latch;
                  state_nxt.ifr  = vrf_pkg::clear_flags(state_cur.ifr, state_cur.ier,
                                                        vrf_pkg::FLAG_T2);
               end
               vrf_pkg::REG_ACR: state_nxt.acr = item.write_data;
               vrf_pkg::REG_IER: begin
                  state_nxt.ier    = ier_new;
                  state_nxt.ifr    = ifr_sum;
                  result.irq_pulse = ifr_sum[7];
               end
               vrf_pkg::REG_IFR: begin
                  state_nxt.ifr = vrf_pkg::clear_flags(state_cur.ifr, state_cur.ier,
                                                       item.write_data);
               end
               vrf_pkg::REG_ORANH: begin
                  state_nxt.oranh = pa_new;
                  if (vrf_pkg::strobe_sel(state_cur.orb)) begin
                     result.device_strobe = 1'b1;
                     result.device_data   = pa_new;
                  end
               end
               default: result = '0;
            endcase
         end
         default: result = '0;
      endcase
   end

endmodule

`default_nettype wire

FILE: dv/via_regfile_predict_check.sv
// checker for the via register file: watches both streams, predicts each
// access result and compares it field by field; depends on vrf_pkg
`timescale 1ns / 1ps

module via_regfile_predict_check (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   input  wire         req_tready,
   // reg_addr[3:0], write_data[11:4], raise_flags[18:12], zero [23:19]
   input  wire  [23:0] req_tdata,
   // mode[1:0]
   input  wire  [1:0]  req_tuser,
   input  wire         rsp_tvalid,
   input  wire         rsp_tready,
   // read_data[7:0], access_error[8], irq_pulse[9], latch_valid[10],
   // latch_index[13:11], latch_bit[14], device_strobe[15], device_data[23:16]
   input  wire  [23:0] rsp_tdata,
   output int          mismatch_count,
   output int          awaited_count,
   output int          checked_count
);

   // predicted adapter state
   logic [7:0]  regs [16];
   logic [7:0]  t2_low;
   logic [15:0] t1_cnt;
   logic [15:0] t2_cnt;
   logic        t2_armed;
   logic        t1_free;
   logic        t2_pulse;

   vrf_pkg::result_type access_results_q[$];
   int          mismatches = 0;
   int          awaited = 0;
   int          checked = 0;

   assign mismatch_count = mismatches;
   assign awaited_count  = awaited;
   assign checked_count  = checked;

   function automatic void clear_model();
      for (int i = 0; i < 16; i++) begin
         regs[i] = 8'h00;
      end
      regs[vrf_pkg::REG_ORB] = vrf_pkg::ORB_RESET;
      t2_low   = 8'h00;
      t1_cnt   = vrf_pkg::COUNT_RESET;
      t2_cnt   = vrf_pkg::COUNT_RESET;
      t2_armed = 1'b0;
      t1_free  = 1'b1;
      t2_pulse = 1'b0;
   endfunction

   // summary bit follows any pending enabled flag
   function automatic void refresh_summary();
      logic [7:0] f;
      f = regs[vrf_pkg::REG_IFR] & vrf_pkg::FLAG_MASK;
      if ((f & regs[vrf_pkg::REG_IER] & vrf_pkg::FLAG_MASK) != 8'h00) begin
         f = f | vrf_pkg::IRQ_SUMMARY;
      end
      regs[vrf_pkg::REG_IFR] = f;
   endfunction

   function automatic void drop_flags(input logic [7:0] mask);
      regs[vrf_pkg::REG_IFR] = regs[vrf_pkg::REG_IFR] & ~mask;
      refresh_summary();
   endfunction

   // cb1 always goes, cb2 only outside the independent cb2 modes
   function automatic void drop_port_b_flags();
      logic [7:0] sel;
      logic [7:0] mask;
      sel  = regs[vrf_pkg::REG_PCR] & vrf_pkg::PCR_CB2_SEL;
      mask = vrf_pkg::FLAG_CB1;
      if (sel != vrf_pkg::PCR_CB2_IND_A && sel != vrf_pkg::PCR_CB2_IND_B) begin
         mask = mask | vrf_pkg::FLAG_CB2;
      end
      drop_flags(mask);
   endfunction

   function automatic logic addresses_device(input logic [7:0] pb);
      return !pb[3] && (pb[2:0] == 3'd0 || pb[2:0] == 3'd2 || pb[2:0] == 3'd3);
   endfunction

   // port b write through ddrb, drives the addressable latch
   function automatic vrf_pkg::result_type drive_port_b(input logic [7:0] val,
                                                        input vrf_pkg::result_type r);
      logic [7:0] nv;
      nv = (regs[vrf_pkg::REG_ORB] & ~regs[vrf_pkg::REG_DDRB]) |
           (val & regs[vrf_pkg::REG_DDRB]);
      regs[vrf_pkg::REG_ORB] = nv;
      r.latch_valid = 1'b1;
      r.latch_index = nv[2:0];
      r.latch_bit   = nv[3];
      if (addresses_device(nv)) begin
         r.device_strobe = 1'b1;
         r.device_data   = regs[vrf_pkg::REG_ORANH];
      end else begin
         r.device_strobe = 1'b0;
         r.device_data   = 8'h00;
      end
      drop_port_b_flags();
      return r;
   endfunction

   // one bus access: update the predicted state and return its result
   function automatic vrf_pkg::result_type predict_access(input vrf_pkg::mode_type m,
                                                          input vrf_pkg::reg_addr_type a,
                                                          input logic [7:0] wd,
                                                          input logic [6:0] rf);
      vrf_pkg::result_type r;
      logic [7:0] nv;
      r = '0;
      case (m)
         vrf_pkg::MODE_RAISE: begin
            regs[vrf_pkg::REG_IFR] = regs[vrf_pkg::REG_IFR] | {1'b0, rf};
            if ((regs[vrf_pkg::REG_IER] & {1'b0, rf}) != 8'h00) begin
               regs[vrf_pkg::REG_IFR] = regs[vrf_pkg::REG_IFR] | vrf_pkg::IRQ_SUMMARY;
               r.irq_pulse = 1'b1;
            end
         end
         vrf_pkg::MODE_NONE: begin
         end
         default: begin
            if (a == vrf_pkg::REG_ORA || a == vrf_pkg::REG_SR) begin
               r.access_error = 1'b1;
            end else if (m == vrf_pkg::MODE_READ) begin
               case (a)
                  vrf_pkg::REG_ORB: begin
                     drop_port_b_flags();
                     r.read_data = regs[vrf_pkg::REG_ORB];
                  end
                  vrf_pkg::REG_T1CL: begin
                     drop_flags(vrf_pkg::FLAG_T1);
                     r.read_data = t1_cnt[7:0];
                  end
                  vrf_pkg::REG_T1CH: r.read_data = t1_cnt[15:8];
                  vrf_pkg::REG_T2CL: begin
                     t2_armed = 1'b1;
                     r.read_data = regs[vrf_pkg::REG_T2CL];
                  end
                  vrf_pkg::REG_IER: r.read_data = regs[vrf_pkg::REG_IER] | vrf_pkg::IRQ_SUMMARY;
                  default: r.read_data = regs[a];
               endcase
            end else begin
               case (a)
                  vrf_pkg::REG_ORB: r = drive_port_b(wd, r);
                  vrf_pkg::REG_DDRB, vrf_pkg::REG_DDRA, vrf_pkg::REG_PCR,
                  vrf_pkg::REG_T1LH: regs[a] = wd;
                  vrf_pkg::REG_T1CL, vrf_pkg::REG_T1LL: regs[vrf_pkg::REG_T1LL] = wd;
                  // t1 high load also clears pb7 through the port b path
                  vrf_pkg::REG_T1CH: begin
                     regs[vrf_pkg::REG_T1CH] = wd;
                     regs[vrf_pkg::REG_T1LH] = wd;
                     regs[vrf_pkg::REG_T1CL] = regs[vrf_pkg::REG_T1LL];
                     t1_cnt = {wd, regs[vrf_pkg::REG_T1LL]};
                     drop_flags(vrf_pkg::FLAG_T1);
                     drop_port_b_flags();
                     r = drive_port_b(regs[vrf_pkg::REG_ORB] & vrf_pkg::PB7_CLEAR, r);
                  end
                  vrf_pkg::REG_T2CL: t2_low = wd;
                  vrf_pkg::REG_T2CH: begin
                     regs[vrf_pkg::REG_T2CH] = wd;
                     regs[vrf_pkg::REG_T2CL] = t2_low;
                     t2_cnt = {wd, t2_low};
                     t2_armed = 1'b1;
                     drop_flags(vrf_pkg::FLAG_T2);
                  end
                  vrf_pkg::REG_ACR: begin
                     regs[vrf_pkg::REG_ACR] = wd;
                     t1_free  = wd[6];
                     t2_pulse = wd[5];
                  end
                  // bit 7 picks set or clear of the enables
                  vrf_pkg::REG_IER: begin
                     if (wd[7]) begin
                        regs[vrf_pkg::REG_IER] = (regs[vrf_pkg::REG_IER] | wd) &
                                                 vrf_pkg::FLAG_MASK;
                     end else begin
                        regs[vrf_pkg::REG_IER] = regs[vrf_pkg::REG_IER] & ~wd &
                                                 vrf_pkg::FLAG_MASK;
                     end
                     refresh_summary();
                     r.irq_pulse = regs[vrf_pkg::REG_IFR][7];
                  end
                  vrf_pkg::REG_IFR: drop_flags(wd);
                  default: begin
                     nv = (regs[vrf_pkg::REG_ORANH] & ~regs[vrf_pkg::REG_DDRA]) |
                          (wd & regs[vrf_pkg::REG_DDRA]);
                     regs[vrf_pkg::REG_ORANH] = nv;
                     if (addresses_device(regs[vrf_pkg::REG_ORB])) begin
                        r.device_strobe = 1'b1;
                        r.device_data   = nv;
                     end
                  end
               endcase
            end
         end
      endcase
      return r;
   endfunction

   function automatic void compare_field(input string name, input logic [7:0] want,
                                         input logic [7:0] got);
      if (got !== want) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
   endfunction

   // predict on each access transfer, compare on each result transfer
   always @(posedge clock) begin
      vrf_pkg::result_type want;
      vrf_pkg::result_type got;
      if (reset) begin
         clear_model();
         access_results_q.delete();
      end else begin
         if (req_tvalid && req_tready) begin
            access_results_q.push_back(
               predict_access(vrf_pkg::mode_type'(req_tuser),
                              vrf_pkg::reg_addr_type'(req_tdata[3:0]),
                              req_tdata[11:4], req_tdata[18:12]));
         end
         if (rsp_tvalid === 1'b1 && rsp_tready) begin
            got = vrf_pkg::result_type'(rsp_tdata);
            if (access_results_q.size() == 0) begin
               mismatches++;
               $display("%0t: result with none expected, expected nothing, actual %h",
                        $time, rsp_tdata);
            end else begin
               want = access_results_q.pop_front();
               compare_field("read_data", want.read_data, got.read_data);
               compare_field("access_error", 8'(want.access_error), 8'(got.access_error));
               compare_field("irq_pulse", 8'(want.irq_pulse), 8'(got.irq_pulse));
               compare_field("latch_valid", 8'(want.latch_valid), 8'(got.latch_valid));
               compare_field("latch_index", 8'(want.latch_index), 8'(got.latch_index));
               compare_field("latch_bit", 8'(want.latch_bit), 8'(got.latch_bit));
               compare_field("device_strobe", 8'(want.device_strobe), 8'(got.device_strobe));
               compare_field("device_data", want.device_data, got.device_data);
               checked++;
            end
         end
      end
      awaited = access_results_q.size();
   end

endmodule

FILE: dv/tb_via_register_file_with_irq_logic_core.sv
// testbench top for the via register file: clock, reset, access stimulus,
// result back-pressure and verdict; depends on vrf_pkg, the core and the checker
`timescale 1ns / 1ps

module tb_via_register_file_with_irq_logic_core;

   localparam int IDLE_LIMIT    = 2000;
   localparam int HOLD_CYCLES   = 40;
   localparam int PHASE_ITEMS   = 255;
   localparam int DRAIN_CYCLES  = 4;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;

   int mismatch_count;
   int awaited_count;
   int checked_count;

   int idle_pct = 0;
   int stall_pct = 0;
   int holds_asked = 0;
   int holds_done = 0;
   int hold_left = 0;
   int quiet_cycles = 0;
   int sent_by_mode [4] = '{0, 0, 0, 0};

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   via_register_file_with_irq_logic_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   via_regfile_predict_check access_check (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .mismatch_count (mismatch_count),
      .awaited_count  (awaited_count),
      .checked_count  (checked_count)
   );

   // result side: random stalls, plus a long hold when one is asked for
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left = hold_left - 1;
      end else if (holds_done != holds_asked) begin
         holds_done++;
         hold_left = HOLD_CYCLES - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid === 1'b1 && rsp_tready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= IDLE_LIMIT) begin
         $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                  $time, IDLE_LIMIT, awaited_count);
         $display("Some tests failed");
         $finish;
      end
   end

   // one access transfer; valid stays high into the next call unless it idles
   task automatic send_access(input vrf_pkg::mode_type m, input vrf_pkg::reg_addr_type a,
                              input logic [7:0] wd, input logic [6:0] rf);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= m;
      req_tdata  <= {5'b0, rf, wd, a};
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      sent_by_mode[m]++;
      @(negedge clock);
   endtask

   // sender pause until every result has come back
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do begin
         @(negedge clock);
      end while (awaited_count != 0);
   endtask

   initial begin
      int pick;
      vrf_pkg::mode_type m;
      logic [6:0] rf;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: reset values, masking, latch strobes, flags and timers
      send_access(vrf_pkg::MODE_READ,  vrf_pkg::REG_ORB,   8'h00, 7'h00);
      send_access(vrf_pkg::MODE_READ,  vrf_pkg::REG_T1CL,  8'h00, 7'h00);
      send_access(vrf_pkg::MODE_READ,  vrf_pkg::REG_T1CH,  8'h00, 7'h00);
      send_access(vrf_pkg::MODE_WRITE, vrf_pkg::REG_ORB,   8'hff, 7'h00);  // ddrb still zero
      send_access(vrf_pkg::MODE_WRITE, vrf_pkg::REG_DDRB,  8'hff, 7'h00);
      send_access(vrf_pkg::MODE_WRITE, vrf_pkg::REG_DDRA,  8'hff, 7'h00);
      // latch 0, bit low: strobe
      send_access(vrf_pkg::MODE_WRITE, vrf_pkg::REG_ORANH, 8'ha5, 7'h00);
      // latch 3, bit high: no strobe
      send_access(vrf_pkg::MODE_WRITE, vrf_pkg::REG_ORB,   8'h0b, 7'h00);
      send_access(vrf_pkg::MODE_WRITE, vrf_pkg::REG_ORB,   8'h02, 7'h00);  // latch 2 strobe
      send_access(vrf_pkg::MODE_RAISE, vrf_pkg::REG_ORB,   8'h00, 7'h01);  // not enabled yet
      // enable with a flag pending
      send_access(vrf_pkg::MODE_WRITE, vrf_pkg::REG_IER,   8'hff, 7'h00);
      send_access(vrf_pkg::MODE_RAISE, vrf_pkg::REG_IFR,   8'hff, 7'h7f);
      // independent cb2 keeps cb2
      send_access(vrf_pkg::MODE_WRITE, vrf_pkg::REG_PCR,   8'h20, 7'h00);
      send_access(vrf_pkg::MODE_READ,  vrf_pkg::REG_ORB,   8'h00, 7'h00);
      send_access(vrf_pkg::MODE_READ,  vrf_pkg::REG_IFR,   8'h00, 7'h00);
      send_access(vrf_pkg::MODE_WRITE, vrf_pkg::REG_PCR,   8'h60, 7'h00);
      send_access(vrf_pkg::MODE_WRITE, vrf_pkg::REG_ORB,   8'h80, 7'h00);
      send_access(vrf_pkg::MODE_WRITE, vrf_pkg::REG_T1CL,  8'h34, 7'h00);
      send_access(vrf_pkg::MODE_WRITE, vrf_pkg::REG_T1CH,  8'h92, 7'h00);  // pb7 goes low
      send_access(vrf_pkg::MODE_READ,  vrf_pkg::REG_T1CL,  8'h00, 7'h00);
      send_access(vrf_pkg::MODE_WRITE, vrf_pkg::REG_T2CL,  8'h56, 7'h00);
      send_access(vrf_pkg::MODE_WRITE, vrf_pkg::REG_T2CH,  8'h78, 7'h00);
      send_access(vrf_pkg::MODE_READ,  vrf_pkg::REG_T2CL,  8'h00, 7'h00);
      send_access(vrf_pkg::MODE_WRITE, vrf_pkg::REG_ACR,   8'h60, 7'h00);
      send_access(vrf_pkg::MODE_WRITE, vrf_pkg::REG_IFR,   8'h7f, 7'h00);
      // clear all enables
      send_access(vrf_pkg::MODE_WRITE, vrf_pkg::REG_IER,   8'h7f, 7'h00);
      send_access(vrf_pkg::MODE_READ,  vrf_pkg::REG_IER,   8'h00, 7'h00);
      send_access(vrf_pkg::MODE_READ,  vrf_pkg::REG_ORA,   8'h00, 7'h00);
      send_access(vrf_pkg::MODE_WRITE, vrf_pkg::REG_SR,    8'hff, 7'h7f);
      send_access(vrf_pkg::MODE_NONE,  vrf_pkg::REG_ORA,   8'hff, 7'h7f);
      wait_drained();

      // random accesses under four idle/stall mixes
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 70; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 70; end
            default: begin idle_pct = 28; stall_pct = 28; end
         endcase
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // long result hold while accesses keep coming
            if (phase == 0 && n == 100) begin
               holds_asked++;
            end
            pick = $urandom_range(99);
            m = (pick < 35) ? vrf_pkg::MODE_READ : (pick < 77) ? vrf_pkg::MODE_WRITE :
                (pick < 95) ? vrf_pkg::MODE_RAISE : vrf_pkg::MODE_NONE;
            // sparse raises half of the time so flag clears stay visible
            if ($urandom_range(1) == 0) begin
               rf = 7'(1 << $urandom_range(6));
            end else begin
               rf = 7'($urandom_range(127));
            end
            send_access(m, vrf_pkg::reg_addr_type'($urandom_range(15)),
                        8'($urandom_range(255)), rf);
         end
         wait_drained();
      end

      repeat (DRAIN_CYCLES) @(negedge clock);
      $display("covered %0d accesses: %0d reads, %0d writes, %0d flag raises, %0d unused mode",
               sent_by_mode[vrf_pkg::MODE_READ] + sent_by_mode[vrf_pkg::MODE_WRITE] +
               sent_by_mode[vrf_pkg::MODE_RAISE] + sent_by_mode[vrf_pkg::MODE_NONE],
               sent_by_mode[vrf_pkg::MODE_READ], sent_by_mode[vrf_pkg::MODE_WRITE],
               sent_by_mode[vrf_pkg::MODE_RAISE], sent_by_mode[vrf_pkg::MODE_NONE]);
      $display("%0d results compared across four idle/stall mixes and a long result hold",
               checked_count);
      if (mismatch_count == 0 && awaited_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

FILE: via_register_file_with_irq_logic_core.f
hw/rtl/vrf_pkg.sv
hw/rtl/vrf_exec.sv
hw/rtl/via_register_file_with_irq_logic_core.sv
dv/via_regfile_predict_check.sv
dv/tb_via_register_file_with_irq_logic_core.sv
